/* rtl/rpn_pkg.sv */
// shared types, constants and command codes of the rpn stack calculator
package rpn_pkg;

  localparam int unsigned StackDepthDef = 128;
  localparam int unsigned ValW = 32;

  typedef enum logic [3:0] {
    CmdPush  = 4'd0,
    CmdAdd   = 4'd1,
    CmdSub   = 4'd2,
    CmdMul   = 4'd3,
    CmdDiv   = 4'd4,
    CmdMod   = 4'd5,
    CmdPop   = 4'd6,
    CmdPeek  = 4'd7,
    CmdDup   = 4'd8,
    CmdSwap  = 4'd9,
    CmdFlush = 4'd10
  } cmd_e;

  // request and reply between sequencer and divider
  typedef struct packed {
    logic              start;
    logic              is_mod;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] res;
    logic               sat;
  } div_rsp_t;

endpackage

/* rtl/rpn_ram.sv */
// generic single-port-write, single-read ram with registered read
module rpn_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/rpn_div.sv */
// radix-2 restoring divider for q16.16 div and integer mod
module rpn_div
  import rpn_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned NumW = 48;

  logic            busy_q, busy_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [NumW-1:0] num_q, num_d;   // dividend magnitude, shifted out msb first
  logic [31:0]     den_q, den_d;
  logic [32:0]     rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic            neg_q, neg_d;   // quotient negative
  logic            rneg_q, rneg_d; // remainder negative
  logic            mod_q, mod_d;
  logic            done_q, done_d;

  logic [31:0] ma, mb;
  logic [32:0] trial;
  logic [31:0] am, bm;
  logic signed [NumW:0] sq;

  always_comb begin
    // operand magnitudes; mod keeps only the integer part, truncated toward zero
    am = req_i.a[31] ? 32'(-req_i.a) : 32'(req_i.a);
    bm = req_i.b[31] ? 32'(-req_i.b) : 32'(req_i.b);
    if (req_i.is_mod) begin
      ma = {16'd0, am[31:16]};
      mb = {16'd0, bm[31:16]};
    end else begin
      ma = am;
      mb = bm;
    end
  end

  assign trial = {rem_q[31:0], num_q[NumW-1]} - {1'b0, den_q};

  // one quotient bit per cycle
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    rneg_d = rneg_q;
    mod_d  = mod_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'(NumW);
      num_d  = req_i.is_mod ? {16'd0, ma} : {ma, 16'd0};
      den_d  = mb;
      rem_d  = '0;
      quo_d  = '0;
      mod_d  = req_i.is_mod;
      neg_d  = req_i.a[31] ^ req_i.b[31];
      rneg_d = req_i.is_mod ? req_i.a[31] : 1'b0;
    end else if (busy_q) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      if (!trial[32]) begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], num_q[NumW-1]};
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    neg_q  <= neg_d;
    rneg_q <= rneg_d;
    mod_q  <= mod_d;
  end

  // sign fix of the finished quotient or mod remainder, and saturation of the quotient
  always_comb begin
    sq = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    rsp_o.done = done_q;
    rsp_o.sat  = 1'b0;
    if (mod_q) begin
      rsp_o.res = rneg_q ? -$signed({rem_q[15:0], 16'd0}) : $signed({rem_q[15:0], 16'd0});
    end else if (sq > $signed(49'sh0_7FFF_FFFF)) begin
      rsp_o.res = 32'sh7FFF_FFFF;
      rsp_o.sat = 1'b1;
    end else if (sq < -$signed(49'sh0_8000_0000)) begin
      rsp_o.res = 32'sh8000_0000;
      rsp_o.sat = 1'b1;
    end else begin
      rsp_o.res = sq[31:0];
    end
  end

endmodule

/* rtl/rpn_stack_calculator_top.sv */
// rpn stack calculator: command sequencer around the stack ram and the divider
// One command word in, one result word out. The stack lives in a single ram with a
// registered read; the sequencer reads the top entries in turn, works, and writes back.
// Div and mod run on the bit-serial divider that produces one of 48 quotient bits per
// cycle. A new command is taken once the result word has moved into the output
// register, even if it is not yet read. The ram holds unknown data after reset; only
// entries below the pointer are used.
module rpn_stack_calculator_top
  import rpn_pkg::*;
#(
  parameter int unsigned StackDepth = StackDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // cmd[3:0], operand_value[35:4], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // result_value[31:0], result_shown, underflow_error,
                                      // overflow_error, divide_by_zero, arith_saturated
);

  localparam int unsigned AddrW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned PtrW  = $clog2(StackDepth + 1);

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StRdB   = 9'b000000010,
    StRdA   = 9'b000000100,
    StGetA  = 9'b000001000,
    StMul   = 9'b000010000,
    StDiv   = 9'b000100000,
    StSwap  = 9'b001000000,
    StWrite = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic [PtrW-1:0] sp_q, sp_d;
  cmd_e            cmd_q, cmd_d;
  logic signed [31:0] a_q, a_d, b_q, b_d;
  logic [31:0]     res_q, res_d;     // value to push or show
  logic            shown_q, shown_d, und_q, und_d, ovf_q, ovf_d;
  logic            dz_q, dz_d, sat_q, sat_d, push_q, push_d;
  logic signed [63:0] prod_q, prod_d;
  logic            ovalid_q, ovalid_d;
  logic [39:0]     odata_q, odata_d;

  logic            we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0]     wdata, rdata;
  div_req_t        dreq;
  div_rsp_t        drsp;
  logic signed [32:0] sum;
  logic signed [47:0] pf;

  rpn_ram #(.Width(ValW), .Depth(StackDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  rpn_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  // sequencer
  always_comb begin
    state_d  = state_q;
    sp_d     = sp_q;
    cmd_d    = cmd_q;
    a_d      = a_q;
    b_d      = b_q;
    res_d    = res_q;
    shown_d  = shown_q;
    und_d    = und_q;
    ovf_d    = ovf_q;
    dz_d     = dz_q;
    sat_d    = sat_q;
    push_d   = push_q;
    prod_d   = prod_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d  = odata_q;
    we       = 1'b0;
    waddr    = sp_q[AddrW-1:0];
    wdata    = res_q;
    raddr    = AddrW'(sp_q - PtrW'(1));
    dreq     = '0;
    sum      = '0;
    pf       = '0;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          cmd_d   = cmd_e'(s_axis_tdata[3:0]);
          res_d   = '0;
          shown_d = 1'b0;
          und_d   = 1'b0;
          ovf_d   = 1'b0;
          dz_d    = 1'b0;
          sat_d   = 1'b0;
          push_d  = 1'b0;
          a_d     = '0;
          b_d     = '0;
          state_d = StOut;
          case (s_axis_tdata[3:0])
            CmdPush: begin
              res_d   = s_axis_tdata[35:4];
              push_d  = 1'b1;
              state_d = StWrite;
            end
            CmdFlush: sp_d = '0;
            CmdPeek, CmdPop, CmdDup: begin
              if (sp_q == '0) und_d = 1'b1;
              else state_d = StRdB;
            end
            CmdSwap: begin
              if (sp_q < PtrW'(2)) und_d = 1'b1;
              else state_d = StRdB;
            end
            CmdAdd, CmdSub, CmdMul: begin
              if (sp_q == '0) begin
                und_d   = 1'b1;
                state_d = StRdA;
              end else state_d = StRdB;
            end
            // empty stack pops a zero divisor: flag both, stack unchanged
            CmdDiv, CmdMod: begin
              if (sp_q == '0) begin
                und_d = 1'b1;
                dz_d  = 1'b1;
              end else state_d = StRdB;
            end
            default: ;
          endcase
        end
      end
      // read of the top entry was issued from idle; capture it here
      StRdB: begin
        raddr   = AddrW'(sp_q - PtrW'(2));
        b_d     = rdata;
        state_d = StRdA;
        case (cmd_q)
          CmdPeek: begin
            res_d = rdata; shown_d = 1'b1; state_d = StOut;
          end
          CmdPop: begin
            res_d = rdata; shown_d = 1'b1; sp_d = sp_q - PtrW'(1); state_d = StOut;
          end
          CmdDup: begin
            res_d = rdata; push_d = 1'b1; state_d = StWrite;
          end
          CmdSwap: state_d = StSwap;
          default: begin
            sp_d = sp_q - PtrW'(1);
            // integer part of the mod divisor is zero for -1 < b < 1
            if ((cmd_q == CmdDiv && rdata == '0) ||
                (cmd_q == CmdMod && (rdata[31:16] == 16'h0000 ||
                  (rdata[31:16] == 16'hFFFF && rdata[15:0] != 16'h0000)))) begin
              dz_d = 1'b1; state_d = StOut;
            end
          end
        endcase
      end
      // second operand read was issued at pointer minus one
      StRdA: begin
        if (sp_q == '0) begin
          und_d = 1'b1;
          a_d   = '0;
        end
        state_d = StGetA;
      end
      StGetA: begin
        if (sp_q != '0) begin
          a_d  = rdata;
          sp_d = sp_q - PtrW'(1);
        end
        push_d  = 1'b1;
        state_d = StWrite;
        case (cmd_q)
          CmdAdd, CmdSub: begin
            sum = (cmd_q == CmdAdd) ? 33'(a_d) + 33'(b_q) : 33'(a_d) - 33'(b_q);
            if (sum > 33'sh0_7FFF_FFFF) begin
              res_d = 32'h7FFF_FFFF; sat_d = 1'b1;
            end else if (sum < -33'sh0_8000_0000) begin
              res_d = 32'h8000_0000; sat_d = 1'b1;
            end else res_d = sum[31:0];
          end
          CmdMul: begin
            prod_d  = 64'(a_d) * 64'(b_q);
            state_d = StMul;
          end
          default: begin
            dreq.start  = 1'b1;
            dreq.is_mod = (cmd_q == CmdMod);
            dreq.a      = a_d;
            dreq.b      = b_q;
            state_d     = StDiv;
          end
        endcase
      end
      // floor shift by 16 then saturation
      StMul: begin
        pf = prod_q[63:16];
        if (pf > 48'sh0_7FFF_FFFF) begin
          res_d = 32'h7FFF_FFFF; sat_d = 1'b1;
        end else if (pf < -48'sh0_8000_0000) begin
          res_d = 32'h8000_0000; sat_d = 1'b1;
        end else res_d = pf[31:0];
        state_d = StWrite;
      end
      StDiv: begin
        if (drsp.done) begin
          res_d   = drsp.res;
          sat_d   = drsp.sat;
          state_d = StWrite;
        end
      end
      // second entry is in rdata; write old top below, then old second on top
      StSwap: begin
        we      = 1'b1;
        waddr   = AddrW'(sp_q - PtrW'(2));
        wdata   = b_q;
        res_d   = rdata;
        push_d  = 1'b1;
        sp_d    = sp_q - PtrW'(1);
        state_d = StWrite;
      end
      StWrite: begin
        if (push_q) begin
          if (sp_q < PtrW'(StackDepth)) begin
            we   = 1'b1;
            sp_d = sp_q + PtrW'(1);
          end else ovf_d = 1'b1;
        end
        if (cmd_q == CmdPush || cmd_q == CmdDup || cmd_q == CmdSwap) res_d = '0;
        if (cmd_q != CmdPush && cmd_q != CmdDup && cmd_q != CmdSwap) res_d = '0;
        state_d = StOut;
      end
      StOut: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = {3'd0, sat_q, dz_q, ovf_q, und_q, shown_q,
                      (shown_q ? res_q : 32'd0)};
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      sp_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sp_q     <= sp_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    a_q     <= a_d;
    b_q     <= b_d;
    res_q   <= res_d;
    shown_q <= shown_d;
    und_q   <= und_d;
    ovf_q   <= ovf_d;
    dz_q    <= dz_d;
    sat_q   <= sat_d;
    push_q  <= push_d;
    prod_q  <= prod_d;
    odata_q <= odata_d;
  end

`ifndef SYNTHESIS
  // pointer never exceeds the stack depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) sp_q <= PtrW'(StackDepth))
    else $error("stack pointer past depth");
  // a result word is only produced from the output state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q) == StOut)
    else $error("result word without output state");
  // ram writes only happen below the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && state_q == StWrite) |-> sp_q < PtrW'(StackDepth))
    else $error("write into full stack");
`endif

endmodule

/* tb/rpn_stack_calculator_top_test.sv */
// testbench of the rpn stack calculator: directed table, random commands, predictor check
`timescale 1ns / 100ps

module rpn_stack_calculator_top_test;
  import rpn_pkg::*;

  localparam int unsigned Depth = StackDepthDef;
  localparam logic [3:0] CmdBadLo = 4'd11;
  localparam logic [3:0] CmdBadHi = 4'd15;

  typedef struct packed {
    logic        sat;
    logic        dz;
    logic        over;
    logic        under;
    logic        shown;
    logic [31:0] val;
  } result_t;

  typedef struct {
    logic [3:0]  cmd;
    logic [31:0] opv;
    logic        chk;
    result_t     res;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  rpn_stack_calculator_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // predictor state
  logic signed [31:0] calc_stack [Depth];
  int unsigned        calc_sp;
  result_t            expected_results[$];
  int unsigned        n_errors;
  int unsigned        n_words_in;
  int unsigned        n_words_out;
  int unsigned        n_div_words;
  bit                 quiet_phase;
  bit                 long_hold;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v,
                                                 inout result_t r);
    if (v > 66'sd2147483647) begin
      r.sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -66'sd2147483648) begin
      r.sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic void calc_push(input logic signed [31:0] v, inout result_t r);
    if (calc_sp < Depth) begin
      calc_stack[calc_sp] = v;
      calc_sp++;
    end else begin
      r.over = 1'b1;
    end
  endfunction

  function automatic logic signed [31:0] calc_pop(inout result_t r);
    if (calc_sp > 0) begin
      calc_sp--;
      return calc_stack[calc_sp];
    end
    r.under = 1'b1;
    return 0;
  endfunction

  // works out the result word of one command and updates the stack copy
  function automatic result_t calc_command(input logic [3:0] cmd,
                                           input logic signed [31:0] opv);
    result_t r;
    logic signed [31:0] a, b, t;
    logic signed [65:0] wide;
    logic signed [63:0] ia, ib;
    r = '0;
    case (cmd)
      CmdPush: calc_push(opv, r);
      CmdAdd, CmdSub: begin
        b = calc_pop(r);
        a = calc_pop(r);
        wide = (cmd == CmdAdd) ? 66'(a) + 66'(b) : 66'(a) - 66'(b);
        calc_push(clamp32(wide, r), r);
      end
      CmdMul: begin
        b = calc_pop(r);
        a = calc_pop(r);
        wide = (66'(a) * 66'(b)) >>> 16;  // arithmetic shift rounds toward minus infinity
        calc_push(clamp32(wide, r), r);
      end
      CmdDiv: begin
        b = calc_pop(r);
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          a = calc_pop(r);
          wide = (66'(a) <<< 16) / 66'(b);
          calc_push(clamp32(wide, r), r);
        end
      end
      CmdMod: begin
        b = calc_pop(r);
        ib = 64'(b) / 64'sd65536;
        if (ib == 0) begin
          r.dz = 1'b1;
        end else begin
          a = calc_pop(r);
          ia = 64'(a) / 64'sd65536;
          t = 32'((ia % ib) * 64'sd65536);
          calc_push(t, r);
        end
      end
      CmdPop: begin
        r.shown = (calc_sp > 0);
        r.val = calc_pop(r);
      end
      CmdPeek: begin
        if (calc_sp > 0) begin
          r.val = calc_stack[calc_sp-1];
          r.shown = 1'b1;
        end else begin
          r.under = 1'b1;
        end
      end
      CmdDup: begin
        if (calc_sp > 0) calc_push(calc_stack[calc_sp-1], r);
        else r.under = 1'b1;
      end
      CmdSwap: begin
        if (calc_sp > 1) begin
          t = calc_stack[calc_sp-1];
          calc_stack[calc_sp-1] = calc_stack[calc_sp-2];
          calc_stack[calc_sp-2] = t;
        end else begin
          r.under = 1'b1;
        end
      end
      CmdFlush: calc_sp = 0;
      default: ;
    endcase
    return r;
  endfunction

  function automatic result_t mk_res(input logic [31:0] v, input logic sh, input logic un,
                                     input logic ov, input logic dz, input logic st);
    result_t r;
    r = '{sat: st, dz: dz, over: ov, under: un, shown: sh, val: v};
    return r;
  endfunction

  // drives one command word; a typed-in expectation is cross-checked with the predictor
  task automatic send_word(input logic [3:0] cmd, input logic [31:0] opv,
                           input bit chk, input result_t typed, input bit gaps);
    result_t r;
    int unsigned idle;
    if (gaps && !quiet_phase && ($urandom_range(0, 5) == 0)) begin
      s_axis_tvalid <= 1'b0;
      idle = $urandom_range(1, 13);
      repeat (idle) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, opv, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    r = calc_command(cmd, opv);
    if (chk && r != typed) begin
      $error("table row cmd %0d: typed result %h, predictor gives %h", cmd, typed, r);
      n_errors++;
    end
    if (cmd == CmdDiv || cmd == CmdMod) n_div_words++;
    expected_results.push_back(r);
    n_words_in++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  // result side: random stalls, one long hold-off, field by field compare
  initial begin : result_side
    result_t got, want;
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
        long_hold = 1'b0;
      end else if (!quiet_phase && ($urandom_range(0, 6) == 0)) begin
        m_axis_tready <= 1'b0;
        stall = $urandom_range(1, 13);
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[36:0]);
        n_words_out++;
        if (expected_results.size() == 0) begin
          $error("result word %h arrived with none expected", m_axis_tdata);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.val !== want.val) begin
            $error("result_value: expected %h, got %h", want.val, got.val); n_errors++;
          end
          if (got.shown !== want.shown) begin
            $error("result_shown: expected %b, got %b", want.shown, got.shown); n_errors++;
          end
          if (got.under !== want.under) begin
            $error("underflow_error: expected %b, got %b", want.under, got.under);
            n_errors++;
          end
          if (got.over !== want.over) begin
            $error("overflow_error: expected %b, got %b", want.over, got.over); n_errors++;
          end
          if (got.dz !== want.dz) begin
            $error("divide_by_zero: expected %b, got %b", want.dz, got.dz); n_errors++;
          end
          if (got.sat !== want.sat) begin
            $error("arith_saturated: expected %b, got %b", want.sat, got.sat); n_errors++;
          end
        end
      end
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(($urandom_range(0, 40) - 20) * 65536);
      3: return 32'($signed($urandom_range(0, 131071)) - 65536);
      4: return 32'(($urandom_range(0, 2000) - 1000) * 65536 + $urandom_range(0, 65535));
      default: return $urandom;
    endcase
  endfunction

  // weighted random command codes, pushes most frequent, sometimes unknown codes
  function automatic logic [3:0] rand_command();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 32) return CmdPush;
    if (k < 40) return CmdAdd;
    if (k < 48) return CmdSub;
    if (k < 56) return CmdMul;
    if (k < 62) return CmdDiv;
    if (k < 67) return CmdMod;
    if (k < 75) return CmdPop;
    if (k < 81) return CmdPeek;
    if (k < 88) return CmdDup;
    if (k < 94) return CmdSwap;
    if (k < 96) return CmdFlush;
    return 4'($urandom_range(CmdBadLo, CmdBadHi));
  endfunction

  // stimulus
  initial begin : stimulus
    row_t dir_rows[$];
    logic [3:0] c;
    n_errors = 0; n_words_in = 0; n_words_out = 0; n_div_words = 0;
    quiet_phase = 1'b0; long_hold = 1'b0; calc_sp = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table: empty stack, extremes, errors, every command
    dir_rows = '{
      '{CmdPop,   32'h0, 1, mk_res(0, 0, 1, 0, 0, 0)},
      '{CmdPeek,  32'h0, 1, mk_res(0, 0, 1, 0, 0, 0)},
      '{CmdDup,   32'h0, 1, mk_res(0, 0, 1, 0, 0, 0)},
      '{CmdSwap,  32'h0, 1, mk_res(0, 0, 1, 0, 0, 0)},
      '{CmdAdd,   32'h0, 1, mk_res(0, 0, 1, 0, 0, 0)},
      '{CmdPush,  32'h7fffffff, 1, mk_res(0, 0, 0, 0, 0, 0)},
      '{CmdDup,   32'h0, 1, mk_res(0, 0, 0, 0, 0, 0)},
      '{CmdAdd,   32'h0, 1, mk_res(0, 0, 0, 0, 0, 1)},
      '{CmdPeek,  32'h0, 1, mk_res(32'h7fffffff, 1, 0, 0, 0, 0)},
      '{CmdPush,  32'h80000000, 1, mk_res(0, 0, 0, 0, 0, 0)},
      '{CmdMul,   32'h0, 1, mk_res(0, 0, 0, 0, 0, 1)},
      '{CmdPop,   32'h0, 1, mk_res(32'h80000000, 1, 0, 0, 0, 0)},
      '{CmdPush,  32'h00050000, 0, '0},
      '{CmdPush,  32'h0, 1, mk_res(0, 0, 0, 0, 0, 0)},
      '{CmdDiv,   32'h0, 1, mk_res(0, 0, 0, 0, 1, 0)},
      '{CmdPush,  32'h00008000, 0, '0},
      '{CmdMod,   32'h0, 1, mk_res(0, 0, 0, 0, 1, 0)},
      '{CmdPush,  32'hfffd0000, 0, '0},
      '{CmdSwap,  32'h0, 0, '0},
      '{CmdSub,   32'h0, 0, '0},
      '{CmdPush,  32'h00030000, 0, '0},
      '{CmdDiv,   32'h0, 0, '0},
      '{CmdPush,  32'hfffe0000, 0, '0},
      '{CmdMod,   32'h0, 0, '0},
      '{CmdBadHi, 32'hffffffff, 1, mk_res(0, 0, 0, 0, 0, 0)},
      '{CmdFlush, 32'h0, 1, mk_res(0, 0, 0, 0, 0, 0)}
    };
    foreach (dir_rows[i])
      send_word(dir_rows[i].cmd, dir_rows[i].opv, dir_rows[i].chk, dir_rows[i].res, 1);

    // fill past full depth while the result side holds off
    long_hold = 1'b1;
    for (int i = 0; i < Depth + 3; i++) send_word(CmdPush, rand_value(), 0, '0, 0);
    send_word(CmdDup, 0, 1, mk_res(0, 0, 0, 1, 0, 0), 0);
    for (int i = 0; i < 20; i++) send_word(rand_command(), rand_value(), 0, '0, 1);
    drain_results();

    // random commands; the last stretch runs without any idling
    for (int i = 0; i < 1750; i++) begin
      if (i == 1500) quiet_phase = 1'b1;
      c = rand_command();
      if (calc_sp > 40 && $urandom_range(0, 3) == 0) c = CmdAdd;
      send_word(c, rand_value(), 0, '0, 1);
      if (i == 700) drain_results();
    end
    drain_results();

    $display("ran %0d command words (%0d div or mod), checked %0d result words",
             n_words_in, n_div_words, n_words_out);
    $display("covered empty, full and zero-divisor cases, saturation and random stalls");
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
